/* hdl/sapq_pkg.sv */
// Package for the sorted array priority queue.
// Holds the queue depth, the request and status codes and the cell command type.
// No dependencies.
`default_nettype none

package sapq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W = 5;
    localparam int OUT_DATA_W = 40;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    // Command broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic                    ins;
        logic                    rem;
        logic signed [VAL_W-1:0] value;
    } t_cell_cmd;

endpackage

`default_nettype wire

/* hdl/sapq_cell.sv */
// One storage cell of the sorted chain.
// Depends on sapq_pkg for the command type and value width.
`default_nettype none

module sapq_cell import sapq_pkg::*; (
    input  wire logic                    i_clk,
    input  wire t_cell_cmd               i_cmd,
    input  wire logic                    i_live,
    input  wire logic                    i_left_live,
    input  wire logic                    i_left_ge,
    input  wire logic signed [VAL_W-1:0] i_left_entry,
    input  wire logic signed [VAL_W-1:0] i_right_entry,
    output logic                         o_ge,
    output logic signed [VAL_W-1:0]      o_entry
);

    logic signed [VAL_W-1:0] r_entry;
    logic signed [VAL_W-1:0] n_entry;
    logic                    w_tail;

    // The first free slot sits right after the last live cell.
    assign w_tail  = !i_live && i_left_live;
    assign o_ge    = i_live && (r_entry >= i_cmd.value);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins) begin
            // Cells from the insert point upward shift up by one place.
            if (i_left_ge) begin
                n_entry = i_left_entry;
            end else if (o_ge || w_tail) begin
                n_entry = i_cmd.value;
            end
        end else if (i_cmd.rem && i_live) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

/* hdl/sapq_ctrl.sv */
// Request handshake, live count and result register of the priority queue.
// Depends on sapq_pkg for codes, widths and the cell command type.
`default_nettype none

module sapq_ctrl import sapq_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire logic                    i_req_type,
    input  wire logic signed [VAL_W-1:0] i_value,
    input  wire logic signed [VAL_W-1:0] i_head,
    input  wire logic                    i_m_ready,
    output logic                         o_ready,
    output t_cell_cmd                    o_cmd,
    output logic [CNT_W-1:0]             o_count,
    output logic                         o_m_valid,
    output logic signed [VAL_W-1:0]      o_out_value,
    output logic [STATUS_W-1:0]          o_status
);

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_value;
    logic signed [VAL_W-1:0] n_out_value;
    logic [STATUS_W-1:0]     r_status;
    logic [STATUS_W-1:0]     n_status;
    logic                    w_accept;
    logic                    w_full;
    logic                    w_empty;

    // No request is taken while reset is held, since its result would be dropped.
    assign o_ready  = i_rst_n && (!r_out_valid || i_m_ready);
    assign w_accept = i_valid && o_ready;
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);

    always_comb begin
        o_cmd.ins   = 1'b0;
        o_cmd.rem   = 1'b0;
        o_cmd.value = i_value;
        n_count     = r_count;
        n_out_value = '0;
        n_status    = ST_OK;
        if (i_req_type == REQ_INSERT) begin
            if (w_full) begin
                n_status = ST_OVERFLOW;
            end else begin
                o_cmd.ins = w_accept;
                n_count   = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                n_status = ST_UNDERFLOW;
            end else begin
                o_cmd.rem   = w_accept;
                n_out_value = i_head;
                n_count     = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_value <= n_out_value;
            r_status    <= n_status;
        end
    end

    assign o_count     = r_count;
    assign o_m_valid   = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_status    = r_status;

endmodule

`default_nettype wire

/* hdl/sorted_array_priority_queue.sv */
// Min priority queue held as a chain of sorted storage cells.
// The result of an accepted request is registered and reaches the master side in the cycle after acceptance.
// Throughput: one request per cycle while the downstream side takes each result; every cell updates in the same cycle.
// The result register frees itself when the downstream side takes the result.
// Reset (synchronous, active low) empties the queue; cell contents are not cleared.
`default_nettype none

module sorted_array_priority_queue import sapq_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] in_value
    input  wire logic [0:0]  i_s_tuser,   // [0] req_type
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata    // [31:0] out_value, [33:32] status,
                                          // [38:34] occupancy, [39] zero
);

    t_cell_cmd               w_cmd;
    logic [CNT_W-1:0]        w_count;
    logic [DEPTH-1:0]        w_live;
    logic [DEPTH-1:0]        w_ge;
    logic signed [VAL_W-1:0] w_entry [DEPTH];
    logic signed [VAL_W-1:0] w_out_value;
    logic [STATUS_W-1:0]     w_status;

    sapq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .i_req_type  (i_s_tuser[0]),
        .i_value     (i_s_tdata),
        .i_head      (w_entry[0]),
        .i_m_ready   (i_m_tready),
        .o_ready     (o_s_tready),
        .o_cmd       (w_cmd),
        .o_count     (w_count),
        .o_m_valid   (o_m_tvalid),
        .o_out_value (w_out_value),
        .o_status    (w_status)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign w_live[g] = (CNT_W'(g) < w_count);

        if (g == 0) begin : g_first
            sapq_cell u_cell (
                .i_clk         (i_clk),
                .i_cmd         (w_cmd),
                .i_live        (w_live[g]),
                .i_left_live   (1'b1),
                .i_left_ge     (1'b0),
                .i_left_entry  (w_entry[g]),
                .i_right_entry (w_entry[g+1]),
                .o_ge          (w_ge[g]),
                .o_entry       (w_entry[g])
            );
        end else if (g == DEPTH - 1) begin : g_last
            sapq_cell u_cell (
                .i_clk         (i_clk),
                .i_cmd         (w_cmd),
                .i_live        (w_live[g]),
                .i_left_live   (w_live[g-1]),
                .i_left_ge     (w_ge[g-1]),
                .i_left_entry  (w_entry[g-1]),
                .i_right_entry (w_entry[g]),
                .o_ge          (w_ge[g]),
                .o_entry       (w_entry[g])
            );
        end else begin : g_mid
            sapq_cell u_cell (
                .i_clk         (i_clk),
                .i_cmd         (w_cmd),
                .i_live        (w_live[g]),
                .i_left_live   (w_live[g-1]),
                .i_left_ge     (w_ge[g-1]),
                .i_left_entry  (w_entry[g-1]),
                .i_right_entry (w_entry[g+1]),
                .o_ge          (w_ge[g]),
                .o_entry       (w_entry[g])
            );
        end
    end

    assign o_m_tdata = {1'b0, OCC_W'(w_count), w_status, w_out_value};

endmodule

`default_nettype wire

/* hdl/sapq_checker.sv */
// Port-level checker for the sorted array priority queue, bound to the top level.
// Depends on sapq_pkg for the depth and status codes.
`default_nettype none

module sapq_checker import sapq_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [39:0] o_m_tdata
);

    logic [31:0] w_value;
    logic [1:0]  w_status;
    logic [4:0]  w_occ;

    assign w_value  = o_m_tdata[31:0];
    assign w_status = o_m_tdata[33:32];
    assign w_occ    = o_m_tdata[38:34];

    // A stalled result must not change.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result changed while stalled");

    // An underflow happens only on an empty queue and returns zero.
    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_status == ST_UNDERFLOW |-> w_value == '0 && w_occ == '0)
        else $error("bad underflow result");

    // An overflow happens only on a full queue and returns zero.
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && w_status == ST_OVERFLOW |-> w_value == '0 && w_occ == OCC_W'(DEPTH))
        else $error("bad overflow result");

    // The status field only carries defined codes.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> w_status == ST_OK || w_status == ST_OVERFLOW
                    || w_status == ST_UNDERFLOW)
        else $error("undefined status code");

endmodule

bind sorted_array_priority_queue sapq_checker u_sapq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
